[rtl/core/lcbu_pkg.sv]
// Shared types, constants and width helpers for the lane cell belief update block.
package lcbu_pkg;

   localparam int NUM_CELLS            = 7;
   localparam int IDX_W                = $clog2(NUM_CELLS);
   localparam int CELL_W               = 16;
   localparam int HIT_W                = 16;
   localparam int HIT_FRAC_BITS        = 12;
   localparam int DEF_BELIEF_FRAC_BITS = 15;
   localparam int REQ_DATA_W           = 8;
   localparam int RSP_DATA_W           = NUM_CELLS * CELL_W;
   localparam logic [HIT_W-1:0] HIT_RESET = 16'd4096;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQR,
      ST_RINIT,
      ST_ROOT,
      ST_DINIT,
      ST_DIV,
      ST_STORE,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load;
      logic             sq_step;
      logic             root_init;
      logic             root_step;
      logic             div_init;
      logic             div_step;
      logic             store;
      logic             out_load;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   // Width of the integer square root of the sum of squares.
   function automatic int root_width(input int frac_bits);
      return frac_bits + 7;
   endfunction

   // Divide steps per quotient, at two quotient bits per cycle.
   function automatic int div_steps(input int frac_bits);
      return (frac_bits + 2) / 2;
   endfunction

   function automatic int cnt_width(input int frac_bits);
      return $clog2(root_width(frac_bits) + 1);
   endfunction

   // Cells that receive the hit weight, indexed by {left, center, right}.
   function automatic logic [NUM_CELLS-1:0] hit_mask(input logic [2:0] pattern);
      logic [NUM_CELLS-1:0] m;
      unique case (pattern)
         3'd0:    m = 7'h41;
         3'd1:    m = 7'h1F;
         3'd2:    m = 7'h2A;
         3'd3:    m = 7'h1E;
         3'd4:    m = 7'h7C;
         3'd5:    m = 7'h14;
         3'd6:    m = 7'h3C;
         default: m = 7'h08;
      endcase
      return m;
   endfunction

endpackage

[rtl/core/lcbu_ctrl.sv]
// Sequencer for one update: square-accumulate, square root, per-cell divide, output.
module lcbu_ctrl #(
   parameter int BELIEF_FRAC_BITS = lcbu_pkg::DEF_BELIEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output lcbu_pkg::cmd_type cmd
);

   localparam int RW = lcbu_pkg::root_width(BELIEF_FRAC_BITS);
   localparam int DC = lcbu_pkg::div_steps(BELIEF_FRAC_BITS);
   localparam int CW = lcbu_pkg::cnt_width(BELIEF_FRAC_BITS);
   localparam int IW = lcbu_pkg::IDX_W;

   lcbu_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [IW-1:0]       cell_ff, cell_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cell_in  = cell_ff;
      unique case (state_ff)
         lcbu_pkg::ST_IDLE: begin
            cnt_in  = '0;
            cell_in = '0;
            if (req_tvalid) begin
               state_in = lcbu_pkg::ST_SQR;
            end
         end
         lcbu_pkg::ST_SQR: begin
            // A final extra step drains the product register into the accumulator.
            if (cnt_ff == CW'(lcbu_pkg::NUM_CELLS)) begin
               cnt_in   = '0;
               state_in = lcbu_pkg::ST_RINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lcbu_pkg::ST_RINIT: begin
            state_in = lcbu_pkg::ST_ROOT;
         end
         lcbu_pkg::ST_ROOT: begin
            if (cnt_ff == CW'(RW - 1)) begin
               cnt_in   = '0;
               state_in = lcbu_pkg::ST_DINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lcbu_pkg::ST_DINIT: begin
            state_in = lcbu_pkg::ST_DIV;
         end
         lcbu_pkg::ST_DIV: begin
            if (cnt_ff == CW'(DC - 1)) begin
               cnt_in   = '0;
               state_in = lcbu_pkg::ST_STORE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lcbu_pkg::ST_STORE: begin
            if (cell_ff == IW'(lcbu_pkg::NUM_CELLS - 1)) begin
               cell_in  = '0;
               state_in = lcbu_pkg::ST_DONE;
            end else begin
               cell_in  = cell_ff + 1'b1;
               state_in = lcbu_pkg::ST_DINIT;
            end
         end
         lcbu_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = lcbu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcbu_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      cmd.idx    = cell_ff;
      unique case (state_ff)
         lcbu_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         lcbu_pkg::ST_SQR: begin
            cmd.sq_step = 1'b1;
            cmd.idx     = cnt_ff[IW-1:0];
         end
         lcbu_pkg::ST_RINIT: begin
            cmd.root_init = 1'b1;
         end
         lcbu_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
         end
         lcbu_pkg::ST_DINIT: begin
            cmd.div_init = 1'b1;
         end
         lcbu_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         lcbu_pkg::ST_STORE: begin
            cmd.store = 1'b1;
         end
         lcbu_pkg::ST_DONE: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcbu_pkg::ST_IDLE;
         cnt_ff       <= '0;
         cell_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cell_ff      <= cell_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register loaded while a beat is still pending");

   a_out_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      cell_ff <= IW'(lcbu_pkg::NUM_CELLS - 1))
      else $error("cell index out of range");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.sq_step, cmd.root_init, cmd.root_step,
                cmd.div_init, cmd.div_step, cmd.store, cmd.out_load}))
      else $error("more than one datapath command at once");

endmodule

[rtl/core/lcbu_dpath.sv]
// Belief storage, squaring accumulator, bit-serial square root and radix-4 divider.
module lcbu_dpath #(
   parameter int BELIEF_FRAC_BITS = lcbu_pkg::DEF_BELIEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lcbu_pkg::cmd_type                   cmd,
   input  logic [2:0]                          flags,
   input  logic                                hit_wr,
   input  logic [lcbu_pkg::HIT_W-1:0]          hit_wdata,
   output logic [lcbu_pkg::RSP_DATA_W-1:0]     rsp_data
);

   localparam int F   = BELIEF_FRAC_BITS;
   localparam int N   = lcbu_pkg::NUM_CELLS;
   localparam int IW  = lcbu_pkg::IDX_W;
   localparam int CW  = lcbu_pkg::CELL_W;
   localparam int BW  = F + 1;
   localparam int SW  = F + 5;
   localparam int PW  = 2 * SW;
   localparam int AW  = PW + 3;
   localparam int RW  = lcbu_pkg::root_width(F);
   localparam int DRW = RW + 1;
   localparam int DQ  = 2 * lcbu_pkg::div_steps(F);
   localparam int HSL = (F >= lcbu_pkg::HIT_FRAC_BITS) ? F - lcbu_pkg::HIT_FRAC_BITS : 0;
   localparam int HSR = (F >= lcbu_pkg::HIT_FRAC_BITS) ? 0 : lcbu_pkg::HIT_FRAC_BITS - F;
   localparam longint unsigned ONE_L   = 64'd1 << F;
   localparam longint unsigned FLOOR_L = ONE_L / 10000;
   localparam longint unsigned RESET_L = (ONE_L * 1428) / 10000;
   localparam logic [BW-1:0] ONE_Q   = BW'(ONE_L);
   localparam logic [BW-1:0] FLOOR_Q = BW'(FLOOR_L);
   localparam logic [BW-1:0] RESET_Q = BW'(RESET_L);

   logic [lcbu_pkg::HIT_W-1:0] hit_ff;
   logic [BW-1:0]              belief_ff [N];
   logic [SW-1:0]              sum_ff    [N];
   logic [PW-1:0]              prod_ff;
   logic [AW-1:0]              acc_ff;
   logic [2*RW-1:0]            rad_ff;
   logic [RW+1:0]              srem_ff;
   logic [RW-1:0]              root_ff;
   logic [DRW-1:0]             drem_ff;
   logic [DQ-1:0]              quo_ff;
   logic [CW*N-1:0]            rsp_data_ff;

   logic [N-1:0]   mask;
   logic [63:0]    hit_wide;
   logic [SW-1:0]  hit_al;
   logic [SW-1:0]  sum_in [N];
   logic [SW-1:0]  sum_sel;
   logic [PW-1:0]  prod_in;
   logic [RW+1:0]  rem_sh, trial;
   logic           sq_ge;
   logic [DRW-1:0] norm_x, r1, r2;
   logic           b1, b2;
   logic [DQ-1:0]  q_shift;
   logic [BW-1:0]  q_sat, new_belief;
   logic           keep;

   assign mask     = lcbu_pkg::hit_mask(flags);
   assign hit_wide = (64'(hit_ff) << HSL) >> HSR;
   assign hit_al   = hit_wide[SW-1:0];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         sum_in[i] = SW'(belief_ff[i]) + (mask[i] ? hit_al : '0);
      end
   end

   assign sum_sel = sum_ff[cmd.idx];
   assign prod_in = PW'(sum_sel) * PW'(sum_sel);

   // Square root: one result bit per cycle, two radicand bits enter each step.
   assign rem_sh = {srem_ff[RW-1:0], rad_ff[2*RW-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign sq_ge  = rem_sh >= trial;

   // Division: two restoring steps per cycle; the remainder stays below twice the norm.
   assign norm_x = DRW'(root_ff);
   assign b1     = drem_ff >= norm_x;
   assign r1     = (b1 ? drem_ff - norm_x : drem_ff) << 1;
   assign b2     = r1 >= norm_x;
   assign r2     = (b2 ? r1 - norm_x : r1) << 1;

   // A padding quotient bit is dropped when the bit count is odd.
   assign q_shift    = quo_ff >> (DQ - BW);
   assign q_sat      = (q_shift > DQ'(ONE_Q)) ? ONE_Q : q_shift[BW-1:0];
   assign keep       = (sum_sel > SW'(FLOOR_Q)) && (root_ff != '0);
   assign new_belief = keep ? q_sat : FLOOR_Q;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= lcbu_pkg::HIT_RESET;
         for (int i = 0; i < N; i++) begin
            belief_ff[i] <= RESET_Q;
         end
      end else begin
         if (hit_wr) begin
            hit_ff <= hit_wdata;
         end
         if (cmd.store) begin
            belief_ff[cmd.idx] <= new_belief;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < N; i++) begin
            sum_ff[i] <= sum_in[i];
         end
         prod_ff <= '0;
         acc_ff  <= '0;
      end
      if (cmd.sq_step) begin
         // The drain cycle points past the last cell and feeds a zero product.
         prod_ff <= (cmd.idx < IW'(N)) ? prod_in : '0;
         acc_ff  <= acc_ff + AW'(prod_ff);
      end
      if (cmd.root_init) begin
         rad_ff  <= (2*RW)'(acc_ff);
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.root_step) begin
         rad_ff  <= rad_ff << 2;
         srem_ff <= sq_ge ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[RW-2:0], sq_ge};
      end
      if (cmd.div_init) begin
         drem_ff <= DRW'(sum_sel);
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         drem_ff <= r2;
         quo_ff  <= {quo_ff[DQ-3:0], b1, b2};
      end
      if (cmd.out_load) begin
         for (int i = 0; i < N; i++) begin
            rsp_data_ff[CW*i +: CW] <= CW'(belief_ff[i]);
         end
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

[rtl/core/lane_cell_belief_update_core.sv]
// Lane cell belief update: seven-cell histogram filter measurement step with L2 normalization.
// An accepted beat runs square-accumulate, square root and a divide for each of the seven cells,
// with RW = BELIEF_FRAC_BITS + 7 square-root steps and DC = (BELIEF_FRAC_BITS + 2) / 2 divide
// steps per cell, before its result beat is loaded into the output register.
// A new beat is taken only once the previous one is finished; a finished result waits for the
// output register and holds off the next beat.
// Reset (synchronous): belief cells go to 0.1428, the hit weight to 1.0, no result is pending.
module lane_cell_belief_update_core #(
   parameter int BELIEF_FRAC_BITS = lcbu_pkg::DEF_BELIEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // left_seen [0], center_seen [1], right_seen [2], zero [7:3]
   input  logic [lcbu_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // cell0 [15:0], cell1 [31:16], ... cell6 [111:96]
   output logic [lcbu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [lcbu_pkg::HIT_W-1:0]          csr_wr_data
);

   lcbu_pkg::cmd_type cmd;

   lcbu_ctrl #(
      .BELIEF_FRAC_BITS(BELIEF_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd)
   );

   lcbu_dpath #(
      .BELIEF_FRAC_BITS(BELIEF_FRAC_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .flags    ({req_tdata[0], req_tdata[1], req_tdata[2]}),
      .hit_wr   (csr_wr_en),
      .hit_wdata(csr_wr_data),
      .rsp_data (rsp_tdata)
   );

endmodule

[tb/sv/tb_lane_cell_belief_update_core.sv]
// Self-checking testbench for the lane cell belief update core.
module tb_lane_cell_belief_update_core;

   localparam int FRAC         = lcbu_pkg::DEF_BELIEF_FRAC_BITS;
   localparam int NCELLS       = lcbu_pkg::NUM_CELLS;
   localparam longint unsigned CELL_ONE     = 64'd1 << FRAC;
   localparam longint unsigned CELL_FLOOR   = CELL_ONE / 10000;
   localparam longint unsigned BELIEF_START = (CELL_ONE * 1428) / 10000;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 120;
   localparam int HOLD_CYCLES   = 400;

   // Cells that take the hit weight, indexed by {left, center, right}.
   localparam logic [NCELLS-1:0] CELL_HITS [8] = '{
      7'h41, 7'h1F, 7'h2A, 7'h1E, 7'h7C, 7'h14, 7'h3C, 7'h08
   };

   typedef logic [NCELLS-1:0][lcbu_pkg::CELL_W-1:0] cells_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   // left_seen [0], center_seen [1], right_seen [2], zero [7:3]
   logic [lcbu_pkg::REQ_DATA_W-1:0]     req_tdata;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   // cell0 [15:0], cell1 [31:16], ... cell6 [111:96]
   logic [lcbu_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                csr_wr_en;
   logic [lcbu_pkg::HIT_W-1:0]          csr_wr_data;

   // Predictor state: kept belief and the hit weight as last written.
   longint unsigned             model_belief [NCELLS];
   logic [lcbu_pkg::HIT_W-1:0]  hit_weight;
   cells_type                   pending_beliefs [$];

   bit          gaps_on = 1'b1;
   bit          hold_pending = 1'b0;
   int unsigned updates_sent = 0;
   int unsigned beliefs_checked = 0;
   int unsigned hit_writes = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   lane_cell_belief_update_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // Measurement update: add the hit weight to masked cells, then L2-normalize.
   function automatic cells_type predict_update(input logic left, input logic center,
                                                input logic right);
      logic [NCELLS-1:0] hits;
      longint unsigned   sums [NCELLS];
      longint unsigned   hit_q;
      longint unsigned   energy;
      longint unsigned   norm;
      longint unsigned   quo;
      cells_type         cells;
      hits   = CELL_HITS[{left, center, right}];
      hit_q  = 64'(hit_weight) << (FRAC - lcbu_pkg::HIT_FRAC_BITS);
      energy = 0;
      for (int i = 0; i < NCELLS; i++) begin
         sums[i] = model_belief[i] + (hits[i] ? hit_q : 64'd0);
         energy += sums[i] * sums[i];
      end
      norm = int_root(energy);
      for (int i = 0; i < NCELLS; i++) begin
         if (sums[i] > CELL_FLOOR && norm != 0) begin
            quo = (sums[i] << FRAC) / norm;
            if (quo > CELL_ONE) quo = CELL_ONE;
         end else begin
            quo = CELL_FLOOR;
         end
         model_belief[i] = quo;
         cells[i] = quo[lcbu_pkg::CELL_W-1:0];
      end
      return cells;
   endfunction

   task automatic send_update(input logic left, input logic center, input logic right);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, right, center, left};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_beliefs.push_back(predict_update(left, center, right));
      updates_sent++;
   endtask

   task automatic send_random_update();
      logic [2:0] flags;
      flags = 3'($urandom_range(0, 7));
      send_update(flags[2], flags[1], flags[0]);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_beliefs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The register is only written with the block idle.
   task automatic write_hit(input logic [lcbu_pkg::HIT_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      hit_weight = value;
      hit_writes++;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_reset_state();
      send_update(1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_every_pattern();
      for (int rep = 0; rep < 2; rep++) begin
         for (int p = 0; p < 8; p++) begin
            send_update(p[2], p[1], p[0]);
         end
      end
   endtask

   task automatic test_hit_extremes();
      write_hit(16'h0000);
      send_update(1'b1, 1'b1, 1'b1);
      send_update(1'b0, 1'b1, 1'b0);
      write_hit(16'hFFFF);
      send_update(1'b1, 1'b0, 1'b0);
      send_update(1'b0, 1'b0, 1'b1);
      write_hit(16'h0001);
      send_update(1'b1, 1'b1, 1'b0);
   endtask

   task automatic test_random_updates(input int phases, input int per_phase);
      logic [lcbu_pkg::HIT_W-1:0] value;
      for (int ph = 0; ph < phases; ph++) begin
         case ($urandom_range(0, 5))
            0:       value = 16'h0000;
            1:       value = 16'hFFFF;
            2:       value = 16'($urandom_range(1, 255));
            3:       value = 16'($urandom_range(0, 65535));
            default: value = 16'($urandom_range(0, 8192));
         endcase
         write_hit(value);
         gaps_on = (ph % 3 != 2);
         repeat (per_phase) send_random_update();
      end
      gaps_on = 1'b1;
   endtask

   // The receiver stalls while the sender keeps offering beats.
   task automatic test_backpressure();
      hold_pending = 1'b1;
      repeat (8) send_random_update();
   endtask

   task automatic test_sender_pause();
      wait_drained();
      repeat (4) send_random_update();
   endtask

   task automatic test_quiet_tail();
      gaps_on = 1'b0;
      repeat (100) send_random_update();
   endtask

   // Receiver side: random stall bursts, plus one long hold on request.
   initial begin : rsp_side
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cells_type seen;
      cells_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = cells_type'(rsp_tdata);
         if (pending_beliefs.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_beliefs.pop_front();
            for (int i = 0; i < NCELLS; i++) begin
               if (seen[i] !== want[i]) begin
                  $display("%0t: cell%0d expected %0d actual %0d", $time, i, want[i], seen[i]);
                  mismatch_count++;
               end
            end
            beliefs_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time,
                  pending_beliefs.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      for (int i = 0; i < NCELLS; i++) model_belief[i] = BELIEF_START;
      hit_weight = lcbu_pkg::HIT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_every_pattern();
      test_hit_extremes();
      test_random_updates(10, 85);
      test_backpressure();
      test_sender_pause();
      test_quiet_tail();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d update beats over %0d hit weight settings, checked %0d results.",
               updates_sent, hit_writes + 1, beliefs_checked);
      $display("Covered all flag patterns, weight extremes, long output stall and idle pause.");
      if (mismatch_count == 0 && pending_beliefs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/lcbu_pkg.sv
rtl/core/lcbu_ctrl.sv
rtl/core/lcbu_dpath.sv
rtl/core/lane_cell_belief_update_core.sv
tb/sv/tb_lane_cell_belief_update_core.sv
